FILE: rtl/core/covariance_from_integer_sums_defines.svh
// ----------------------------------------------------------------------------
// covariance from integer sums: assertion macros
// shared property forms for the checker, sampled on clk with rst as reset
// ----------------------------------------------------------------------------
`ifndef COVARIANCE_FROM_INTEGER_SUMS_DEFINES_SVH
`define COVARIANCE_FROM_INTEGER_SUMS_DEFINES_SVH

// same-cycle implication, off during reset
`define CVS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what holds on the cycle after reset
`define CVS_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// payload types and widths shared by the covariance datapath
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int SUM_W = 64;
  localparam int CNT_W = 63;

  typedef struct packed {
    logic signed [SUM_W-1:0] cross_sum;
    logic [CNT_W-1:0]        cross_count;
    logic signed [SUM_W-1:0] first_sum;
    logic [CNT_W-1:0]        first_count;
    logic signed [SUM_W-1:0] second_sum;
    logic [CNT_W-1:0]        second_count;
  } cvs_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] covariance;
    logic                    saturated;
    logic                    bad_count;
  } cvs_out_t;

  // classified item: sign and magnitude of each sum, counts as given
  typedef struct packed {
    logic             bad;
    logic             neg_c;
    logic             neg_1;
    logic             neg_2;
    logic [SUM_W-1:0] mag_c;
    logic [SUM_W-1:0] mag_1;
    logic [SUM_W-1:0] mag_2;
    logic [CNT_W-1:0] cnt_c;
    logic [CNT_W-1:0] cnt_1;
    logic [CNT_W-1:0] cnt_2;
  } cvs_work_t;

endpackage

FILE: rtl/core/cvs_fifo.sv
// ----------------------------------------------------------------------------
// cvs_fifo
// small show-ahead queue in registers, one push and one pop per cycle
// ----------------------------------------------------------------------------
module cvs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/cvs_front.sv
// ----------------------------------------------------------------------------
// cvs_front
// splits each sum into sign and magnitude and flags a zero count
// ----------------------------------------------------------------------------
module cvs_front import cvs_pkg::*; (
  input  cvs_in_t   sums,
  output cvs_work_t work
);

  always_comb begin
    work.bad   = (sums.cross_count == '0) || (sums.first_count == '0) ||
                 (sums.second_count == '0);
    work.neg_c = sums.cross_sum[SUM_W-1];
    work.neg_1 = sums.first_sum[SUM_W-1];
    work.neg_2 = sums.second_sum[SUM_W-1];
    // most negative sum maps to magnitude 2^63, still fits unsigned
    work.mag_c = work.neg_c ? (~sums.cross_sum + 1'b1) : sums.cross_sum;
    work.mag_1 = work.neg_1 ? (~sums.first_sum + 1'b1) : sums.first_sum;
    work.mag_2 = work.neg_2 ? (~sums.second_sum + 1'b1) : sums.second_sum;
    work.cnt_c = sums.cross_count;
    work.cnt_1 = sums.first_count;
    work.cnt_2 = sums.second_count;
  end

endmodule

FILE: rtl/core/cvs_div.sv
// ----------------------------------------------------------------------------
// cvs_div
// pipelined restoring divider, one quotient bit per stage
// dividend is {hi, lo} with hi below den, so the quotient fits QB bits
// ----------------------------------------------------------------------------
module cvs_div #(
  parameter int DW = 63,
  parameter int QB = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [DW-1:0] hi,
  input  logic [QB-1:0] lo,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [QB-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_s  [QB+1];
  logic [QB-1:0] lo_s   [QB+1];
  logic [DW-1:0] den_s  [QB+1];
  logic [SW-1:0] side_s [QB+1];
  logic          v_s    [QB+1];

  assign rem_s[0]  = hi;
  assign lo_s[0]   = lo;
  assign den_s[0]  = den;
  assign side_s[0] = side_in;
  assign v_s[0]    = vin;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem_s[k], lo_s[k][QB-1]};
    assign diff  = trial - {1'b0, den_s[k]};
    assign take  = (trial >= {1'b0, den_s[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        lo_s[k+1]   <= (lo_s[k] << 1) | QB'(take);
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end
  end

  assign vout     = v_s[QB];
  assign quo      = lo_s[QB];
  assign rem      = rem_s[QB];
  assign den_out  = den_s[QB];
  assign side_out = side_s[QB];

endmodule

FILE: rtl/core/cvs_mul.sv
// ----------------------------------------------------------------------------
// cvs_mul
// two-stage 64x64 unsigned multiplier from four 32x32 partial products
// ----------------------------------------------------------------------------
module cvs_mul #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [127:0]  prod,
  output logic [SW-1:0] side_out
);

  logic [63:0]   pp_ll;
  logic [63:0]   pp_lh;
  logic [63:0]   pp_hl;
  logic [63:0]   pp_hh;
  logic [SW-1:0] side_1;
  logic          v_1;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll    <= a[31:0] * b[31:0];
      pp_lh    <= a[31:0] * b[63:32];
      pp_hl    <= a[63:32] * b[31:0];
      pp_hh    <= a[63:32] * b[63:32];
      side_1   <= side_in;
      prod     <= {pp_hh, pp_ll} + (128'(pp_lh) << 32) + (128'(pp_hl) << 32);
      side_out <= side_1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_1  <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v_1  <= vin;
      vout <= v_1;
    end
  end

endmodule

FILE: rtl/core/cvs_back.sv
// ----------------------------------------------------------------------------
// cvs_back
// covariance pipeline: three divisions, products, two divisions of the
// cross terms, fractional divisions, then sum and saturation
// ----------------------------------------------------------------------------
module cvs_back import cvs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      work_valid,
  input  cvs_work_t work,
  output logic      work_take,
  input  logic      res_full,
  output logic      res_push,
  output cvs_out_t  res
);

  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int XW = SUM_W + FW;
  localparam int MW = 130;
  localparam int YW = MW + 1 + FRAC_BITS;
  localparam int AW = YW + 2;
  localparam logic [SUM_W-1:0] COV_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] COV_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic adv;

  // stage one: the three quotients
  logic             v1, bad1, gc1, g11, g21;
  logic [SUM_W-1:0] qc1, q11, q21;
  logic [CNT_W-1:0] rc1, r11, r21, nc1, n11, n21;

  // stage two: products
  logic             v2, bad2, gc2, g12, g22;
  logic [127:0]     prod_a, prod_b, prod_c, prod_d, prod_e;
  logic [SUM_W-1:0] qc2;
  logic [CNT_W-1:0] rc2, nc2, n12, n22;

  // stage three: cross term divisions
  logic             v3, bad3, gc3, g13, g23;
  logic [SUM_W-1:0] p13, p23, qc3;
  logic [CNT_W-1:0] t13, t23, n13, n23, rc3, nc3;
  logic [127:0]     c3;
  logic [125:0]     d3, e3;

  // stage four: fractional terms
  logic             v4, bad4, gc4, g14, g24;
  logic [SUM_W-1:0] p14, p24, qc4;
  logic [127:0]     c4;
  logic [FW-1:0]    fc4, f124, ft14, ft24;

  logic             s1_v, s1_bad, s1_xneg, s1_yneg;
  logic [XW-1:0]    s1_x;
  logic [MW-1:0]    s1_m;
  logic [FW+1:0]    s1_fs;
  logic             s2_v, s2_bad, s2_xneg, s2_yneg;
  logic [XW-1:0]    s2_x;
  logic [YW-1:0]    s2_y;
  logic             s3_v, s3_bad;
  logic [AW-1:0]    s3_xs, s3_ys;
  logic             s4_v, s4_bad;
  logic [AW-1:0]    s4_acc;
  logic [AW-1:0]    xw, yw;
  logic             fits;

  assign adv       = !s4_v || !res_full;
  assign work_take = adv && work_valid;
  assign res_push  = s4_v && !res_full;

  cvs_div #(.DW(CNT_W), .QB(SUM_W), .SW(2)) u_div_c (
    .clk, .rst, .en(adv), .vin(work_valid), .hi('0), .lo(work.mag_c),
    .den(work.cnt_c), .side_in({work.bad, work.neg_c}), .vout(v1),
    .quo(qc1), .rem(rc1), .den_out(nc1), .side_out({bad1, gc1})
  );

  cvs_div #(.DW(CNT_W), .QB(SUM_W), .SW(1)) u_div_1 (
    .clk, .rst, .en(adv), .vin(work_valid), .hi('0), .lo(work.mag_1),
    .den(work.cnt_1), .side_in(work.neg_1), .vout(),
    .quo(q11), .rem(r11), .den_out(n11), .side_out(g11)
  );

  cvs_div #(.DW(CNT_W), .QB(SUM_W), .SW(1)) u_div_2 (
    .clk, .rst, .en(adv), .vin(work_valid), .hi('0), .lo(work.mag_2),
    .den(work.cnt_2), .side_in(work.neg_2), .vout(),
    .quo(q21), .rem(r21), .den_out(n21), .side_out(g21)
  );

  cvs_mul #(.SW(4)) u_mul_a (
    .clk, .rst, .en(adv), .vin(v1), .a({1'b0, r11}), .b(q21),
    .side_in({bad1, gc1, g11, g21}), .vout(v2), .prod(prod_a),
    .side_out({bad2, gc2, g12, g22})
  );

  cvs_mul #(.SW(SUM_W)) u_mul_b (
    .clk, .rst, .en(adv), .vin(v1), .a({1'b0, r21}), .b(q11),
    .side_in(qc1), .vout(), .prod(prod_b), .side_out(qc2)
  );

  cvs_mul #(.SW(2 * CNT_W)) u_mul_c (
    .clk, .rst, .en(adv), .vin(v1), .a(q11), .b(q21),
    .side_in({rc1, nc1}), .vout(), .prod(prod_c), .side_out({rc2, nc2})
  );

  cvs_mul #(.SW(CNT_W)) u_mul_d (
    .clk, .rst, .en(adv), .vin(v1), .a({1'b0, r11}), .b({1'b0, r21}),
    .side_in(n11), .vout(), .prod(prod_d), .side_out(n12)
  );

  cvs_mul #(.SW(CNT_W)) u_mul_e (
    .clk, .rst, .en(adv), .vin(v1), .a({1'b0, n11}), .b({1'b0, n21}),
    .side_in(n21), .vout(), .prod(prod_e), .side_out(n22)
  );

  // r1*q2 is below n1 * 2^64, so its upper half is below n1
  cvs_div #(.DW(CNT_W), .QB(SUM_W), .SW(4 + 2 * CNT_W)) u_div_p1 (
    .clk, .rst, .en(adv), .vin(v2), .hi(prod_a[126:64]), .lo(prod_a[63:0]),
    .den(n12), .side_in({bad2, gc2, g12, g22, rc2, nc2}), .vout(v3),
    .quo(p13), .rem(t13), .den_out(n13),
    .side_out({bad3, gc3, g13, g23, rc3, nc3})
  );

  cvs_div #(.DW(CNT_W), .QB(SUM_W), .SW(SUM_W + 128 + 252)) u_div_p2 (
    .clk, .rst, .en(adv), .vin(v2), .hi(prod_b[126:64]), .lo(prod_b[63:0]),
    .den(n22), .side_in({qc2, prod_c, prod_d[125:0], prod_e[125:0]}),
    .vout(), .quo(p23), .rem(t23), .den_out(n23), .side_out({qc3, c3, d3, e3})
  );

  if (FRAC_BITS > 0) begin : g_frac
    cvs_div #(.DW(CNT_W), .QB(FW), .SW(4)) u_frac_c (
      .clk, .rst, .en(adv), .vin(v3), .hi(rc3), .lo('0), .den(nc3),
      .side_in({bad3, gc3, g13, g23}), .vout(v4), .quo(fc4), .rem(),
      .den_out(), .side_out({bad4, gc4, g14, g24})
    );

    cvs_div #(.DW(126), .QB(FW), .SW(128)) u_frac_12 (
      .clk, .rst, .en(adv), .vin(v3), .hi(d3), .lo('0), .den(e3),
      .side_in(c3), .vout(), .quo(f124), .rem(), .den_out(), .side_out(c4)
    );

    cvs_div #(.DW(CNT_W), .QB(FW), .SW(SUM_W)) u_frac_t1 (
      .clk, .rst, .en(adv), .vin(v3), .hi(t13), .lo('0), .den(n13),
      .side_in(p13), .vout(), .quo(ft14), .rem(), .den_out(), .side_out(p14)
    );

    cvs_div #(.DW(CNT_W), .QB(FW), .SW(2 * SUM_W)) u_frac_t2 (
      .clk, .rst, .en(adv), .vin(v3), .hi(t23), .lo('0), .den(n23),
      .side_in({p23, qc3}), .vout(), .quo(ft24), .rem(), .den_out(),
      .side_out({p24, qc4})
    );
  end else begin : g_nofrac
    assign v4   = v3;
    assign bad4 = bad3;
    assign gc4  = gc3;
    assign g14  = g13;
    assign g24  = g23;
    assign c4   = c3;
    assign p14  = p13;
    assign p24  = p23;
    assign qc4  = qc3;
    assign fc4  = '0;
    assign f124 = '0;
    assign ft14 = '0;
    assign ft24 = '0;
  end

  // x = cross quotient with its fraction, y = product terms with theirs
  assign xw = AW'(s2_x);
  assign yw = AW'(s2_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bad  <= bad4;
      s1_xneg <= gc4;
      s1_yneg <= g14 ^ g24;
      s1_x    <= (XW'(qc4) << FRAC_BITS) | XW'(fc4);
      s1_m    <= MW'(c4) + MW'(p14) + MW'(p24);
      s1_fs   <= (FW+2)'(f124) + (FW+2)'(ft14) + (FW+2)'(ft24);
      s2_bad  <= s1_bad;
      s2_xneg <= s1_xneg;
      s2_yneg <= s1_yneg;
      s2_x    <= s1_x;
      s2_y    <= (YW'(s1_m) << FRAC_BITS) + YW'(s1_fs);
      s3_bad  <= s2_bad;
      s3_xs   <= s2_xneg ? (~xw + 1'b1) : xw;
      s3_ys   <= s2_yneg ? (~yw + 1'b1) : yw;
      s4_bad  <= s3_bad;
      s4_acc  <= s3_xs - s3_ys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (adv) begin
      s1_v <= v4;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  // in range when every bit from the sign of the 64-bit word up agrees
  assign fits = (&s4_acc[AW-1:SUM_W-1]) || !(|s4_acc[AW-1:SUM_W-1]);

  always_comb begin
    res.bad_count = s4_bad;
    res.saturated = !s4_bad && !fits;
    if (s4_bad) begin
      res.covariance = '0;
    end else if (fits) begin
      res.covariance = s4_acc[SUM_W-1:0];
    end else begin
      res.covariance = s4_acc[AW-1] ? COV_MIN : COV_MAX;
    end
  end

endmodule

FILE: rtl/core/covariance_from_integer_sums.sv
// ----------------------------------------------------------------------------
// covariance_from_integer_sums
// fixed-point covariance from a cross sum and two marginal sums with counts
// ----------------------------------------------------------------------------
// throughput: one item per cycle, fully pipelined, while the result queue
//   has room; the bit-per-stage divider chains (64 + 64 + FRAC_BITS
//   stages) set the depth, not the rate
// reset: synchronous, clears both queues and all pipeline valid bits
module covariance_from_integer_sums import cvs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  cvs_in_t  sums,
  output logic     empty,
  input  logic     pop,
  output cvs_out_t result
);

  cvs_work_t work_in;
  cvs_work_t work_q;
  logic      work_empty;
  logic      work_take;
  logic      res_full;
  logic      res_push;
  cvs_out_t  res;

  cvs_front u_front (
    .sums (sums),
    .work (work_in)
  );

  cvs_fifo #(.W($bits(cvs_work_t)), .DEPTH(4)) u_work_q (
    .clk, .rst,
    .push  (push),
    .wdata (work_in),
    .full  (full),
    .pop   (work_take),
    .rdata (work_q),
    .empty (work_empty)
  );

  cvs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .work_valid (!work_empty),
    .work       (work_q),
    .work_take  (work_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  cvs_fifo #(.W($bits(cvs_out_t)), .DEPTH(2)) u_res_q (
    .clk, .rst,
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

FILE: rtl/core/cvs_checker.sv
// ----------------------------------------------------------------------------
// cvs_checker
// port-level checks on the covariance block, bound to the top level
// ----------------------------------------------------------------------------
`include "covariance_from_integer_sums_defines.svh"

module cvs_checker import cvs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input cvs_out_t result
);

  localparam logic [SUM_W-1:0] COV_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] COV_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic cov_zero;
  logic cov_limit;
  logic stalled;

  assign cov_zero  = (result.covariance == '0) && !result.saturated;
  assign cov_limit = (result.covariance == COV_MAX) || (result.covariance == COV_MIN);
  // a result is waiting and the receiver holds off
  assign stalled   = !empty && !pop;

  `CVS_ASSERT(a_bad_zero, !empty && result.bad_count, cov_zero, "bad count result not cleared")

  `CVS_ASSERT(a_sat_limit, !empty && result.saturated, cov_limit, "saturation off the limits")

  `CVS_ASSERT_NEXT(a_hold, stalled, !empty && $stable(result), "result changed before transfer")

  `CVS_ASSERT_RST(a_reset, empty && !full, "queues not empty after reset")

endmodule

bind covariance_from_integer_sums cvs_checker u_checker (.*);
